// File: design/indexed_list_insert_remove_macros.svh
// Assertion macros shared by the indexed list modules.
// Every user must have clk and rst_n in scope.
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILIR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ilir_pkg.sv
// Shared types and codes for the indexed list block.
// No dependencies; every module file imports this package.
package ilir_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Request beat.
    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  position;
        logic [31:0] value;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } rsp_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } cmd_t;

    // Controller states: response register empty or holding a beat.
    typedef enum logic {
        S_EMPTY,
        S_HELD
    } state_t;

endpackage

// File: design/ilir_ctrl.sv
// Handshake controller for the indexed list block.
// Uses ilir_pkg and the assertion macros header.
`include "indexed_list_insert_remove_macros.svh"

module ilir_ctrl
    import ilir_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_stall,
    output logic   rsp_valid,
    input  logic   rsp_stall,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a new request refills the response register, a taken beat empties it.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_EMPTY:
            begin
                if (req_valid)
                begin
                    state_next = S_HELD;
                end
            end
            S_HELD:
            begin
                if (!rsp_stall && !req_valid)
                begin
                    state_next = S_EMPTY;
                end
            end
            default:
            begin
                state_next = S_EMPTY;
            end
        endcase
    end

    // Outputs: a request is taken whenever the response register is free or being drained.
    always_comb
    begin
        rsp_valid = 1'b0;
        req_stall = 1'b0;
        case (state_reg)
            S_EMPTY:
            begin
                rsp_valid = 1'b0;
                req_stall = 1'b0;
            end
            S_HELD:
            begin
                rsp_valid = 1'b1;
                req_stall = rsp_stall;
            end
            default:
            begin
                rsp_valid = 1'b0;
                req_stall = 1'b1;
            end
        endcase
        cmd.exec = req_valid && !req_stall;
    end

    // An executed request always shows up as a response beat in the next cycle.
    `ILIR_ASSERT_NEXT(a_exec_gives_rsp, cmd.exec, rsp_valid, "executed request produced no response")
    // A held response under stall must block new requests.
    `ILIR_ASSERT_IMPL(a_no_exec_when_blocked, rsp_valid && rsp_stall, !cmd.exec, "request executed over a stalled response")
    // A response taken with no new request leaves the register empty.
    `ILIR_ASSERT_NEXT(a_drain_empties, rsp_valid && !rsp_stall && !cmd.exec, !rsp_valid, "response repeated after being taken")

endmodule

// File: design/ilir_dp.sv
// Datapath of the indexed list: a row of entry cells, the count and the response register.
// Uses ilir_pkg and the assertion macros header.
`include "indexed_list_insert_remove_macros.svh"

module ilir_dp
    import ilir_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = CNT_W + 5;

    logic [DATA_WIDTH-1:0] cells_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    logic [CMP_W-1:0]           pos_ext;
    logic [CMP_W-1:0]           cnt_ext;
    logic [IDX_W-1:0]           idx;
    logic [DATA_WIDTH+31:0]     word_ext;
    logic [DATA_WIDTH-1:0]      word;
    logic [DATA_WIDTH+31:0]     rd_ext;
    logic [CNT_W+4:0]           cnt_out_ext;
    logic                       do_ins;
    logic                       do_rem;
    logic                       rd_ok;
    logic [1:0]                 stat;

    // Widen position and count to a common width for comparison.
    assign pos_ext  = {{CNT_W{1'b0}}, req.position};
    assign cnt_ext  = {5'b0, count_reg};
    assign idx      = pos_ext[IDX_W-1:0];
    assign word_ext = {{DATA_WIDTH{1'b0}}, req.value};
    assign word     = word_ext[DATA_WIDTH-1:0];
    assign rd_ext   = {32'b0, cells_reg[idx]};

    // Decode the request and check its position against the count.
    always_comb
    begin
        do_ins = 1'b0;
        do_rem = 1'b0;
        rd_ok  = 1'b0;
        stat   = STAT_DONE;
        case (req.operation)
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    stat = STAT_RANGE;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    stat = STAT_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    stat = STAT_RANGE;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    stat = STAT_RANGE;
                end
                else
                begin
                    do_rem = 1'b1;
                end
            end
            default:
            begin
                stat = STAT_RANGE;
            end
        endcase
    end

    // From the position up, cells shift up on insert (new word at the position) or down on remove.
    always_comb
    begin
        int lower;
        int upper;
        for (int i = 0; i < CAPACITY; i++)
        begin
            lower = (i == 0) ? 0 : i - 1;
            upper = (i == CAPACITY - 1) ? i : i + 1;
            cells_next[i] = cells_reg[i];
            if (cmd.exec && do_ins)
            begin
                if (CMP_W'(i) == pos_ext)
                begin
                    cells_next[i] = word;
                end
                else if (CMP_W'(i) > pos_ext)
                begin
                    cells_next[i] = cells_reg[IDX_W'(lower)];
                end
            end
            else if (cmd.exec && do_rem)
            begin
                if (CMP_W'(i) >= pos_ext)
                begin
                    cells_next[i] = cells_reg[IDX_W'(upper)];
                end
            end
        end
    end

    // Count and response for the current request.
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        cnt_out_ext          = {5'b0, count_next};
        rsp_next.read_value  = rd_ok ? rd_ext[31:0] : 32'b0;
        rsp_next.status      = stat;
        rsp_next.entry_count = cnt_out_ext[4:0];
    end

    // Entry cells carry no reset; only entries below the count are ever returned.
    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
    end

    // Count and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rsp_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    // The count never exceeds the capacity.
    `ILIR_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    // A good insert grows the list by exactly one entry.
    `ILIR_ASSERT_NEXT(a_insert_grows, cmd.exec && do_ins, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow")
    // A rejected request leaves the count alone.
    `ILIR_ASSERT_NEXT(a_reject_keeps, cmd.exec && (stat != STAT_DONE), $stable(count_reg), "rejected request changed the count")
    // Only a good read returns a nonzero word.
    `ILIR_ASSERT_IMPL(a_value_zero, rsp_reg.status != STAT_DONE, rsp_reg.read_value == 32'b0, "failed request returned data")

endmodule

// File: design/indexed_list_insert_remove.sv
// Indexed list with insert, read and remove by position, CAPACITY entries.
// An accepted request's response beat shows in the cycle after it is accepted.
// Throughput: one request per cycle while rsp_stall is low; all entries shift together.
// Reset: asynchronous, clears the count and the handshake state; entry cells are not cleared.
// Depends on ilir_pkg, ilir_ctrl and ilir_dp.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t cmd;

    // Handshake controller.
    ilir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Entry cells, count and response register.
    ilir_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
